/* design/afr_pkg.sv */
// ----------------------------------------------------------------------------
// afr_pkg
// Shared types and constants for the API frame receiver: status codes,
// framing constants and the item and result records between stages.
// ----------------------------------------------------------------------------
package afr_pkg;

  // Framing constants
  localparam logic [7:0]  START_DELIM     = 8'h7E;
  localparam logic [7:0]  GOOD_SUM        = 8'hFF;
  localparam logic [15:0] HDR_LAST_POS    = 16'd3;
  localparam logic [16:0] FRAME_OVERHEAD  = 17'd4;
  localparam logic [15:0] LIMIT_RESET     = 16'd128;

  // Per-byte verdict
  typedef enum logic [1:0] {
    ST_REJECT = 2'd0,
    ST_STORED = 2'd1,
    ST_GOOD   = 2'd2,
    ST_BAD    = 2'd3
  } status_t;

  // Item held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } afr_item_t;

  // Result held in the result register
  typedef struct packed {
    status_t     status;
    logic        overflow_drop;
    logic [7:0]  data_byte;
    logic [15:0] byte_position;
    logic [15:0] payload_length;
    logic [15:0] error_total;
  } afr_result_t;

endpackage

/* design/afr_in_stage.sv */
// ----------------------------------------------------------------------------
// afr_in_stage
// Input register: captures one received byte per item and holds it until
// the deframer core takes it.
// ----------------------------------------------------------------------------
module afr_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  input  logic              take,
  output afr_pkg::afr_item_t item
);
  import afr_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       load;

  // Stall only while a held item cannot move on
  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the byte
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_rx_byte;
    end
  end

  assign item.valid   = valid_r;
  assign item.rx_byte = byte_r;

endmodule

/* design/afr_core.sv */
// ----------------------------------------------------------------------------
// afr_core
// Deframer state and result register: hunts for the start delimiter, reads
// the length, keeps the running sum, gives the verdict and counts errors.
// ----------------------------------------------------------------------------
module afr_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  afr_pkg::afr_item_t  item,
  output logic                take,
  output logic                out_valid,
  input  logic                out_stall,
  output afr_pkg::afr_result_t res
);
  import afr_pkg::*;

  logic [15:0] frame_limit_r;
  logic [15:0] byte_count_r, byte_count_nxt;
  logic [15:0] length_field_r, length_field_nxt;
  logic [7:0]  length_high_r, length_high_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [15:0] err_count_r, err_count_nxt;
  logic        out_valid_r;
  afr_result_t res_r, res_nxt;

  logic        acc;
  logic        ovf;
  logic        reject;
  logic        frame_end;
  logic [15:0] cnt0;
  logic [15:0] len0;
  logic [15:0] err1;
  logic [15:0] cnt_inc;
  logic [7:0]  c;

  // Result register frees up when empty or being taken
  assign take = !out_valid_r || !out_stall;
  assign acc  = item.valid && take;
  assign c    = item.rx_byte;

  // Per-byte frame logic
  always_comb begin
    ovf       = (byte_count_r >= frame_limit_r);
    cnt0      = ovf ? 16'd0 : byte_count_r;
    len0      = ovf ? 16'd0 : length_field_r;
    err1      = err_count_r + {15'd0, ovf};
    reject    = (cnt0 == 16'd0) && (c != START_DELIM);
    cnt_inc   = cnt0 + 16'd1;
    frame_end = 1'b0;

    byte_count_nxt   = cnt0;
    length_field_nxt = len0;
    length_high_nxt  = length_high_r;
    running_sum_nxt  = running_sum_r;
    err_count_nxt    = err1;

    res_nxt.status         = ST_STORED;
    res_nxt.overflow_drop  = ovf;
    res_nxt.data_byte      = c;
    res_nxt.byte_position  = cnt0;
    res_nxt.payload_length = 16'd0;

    if (reject) begin
      // Drop a stray byte while hunting
      err_count_nxt          = err1 + 16'd1;
      res_nxt.status         = ST_REJECT;
      res_nxt.byte_position  = 16'd0;
    end else begin
      byte_count_nxt = cnt_inc;
      if (cnt0 == 16'd0) begin
        running_sum_nxt  = 8'd0;
        length_field_nxt = 16'd0;
      end else if (cnt0 == 16'd1) begin
        length_high_nxt = c;
      end else if (cnt0 == 16'd2) begin
        length_field_nxt = {length_high_r, c};
      end else begin
        running_sum_nxt = running_sum_r + c;
      end
      res_nxt.payload_length = length_field_nxt;

      // Close the frame once length plus overhead bytes are in
      frame_end = (cnt0 >= HDR_LAST_POS) && (length_field_nxt != 16'd0) &&
                  ({1'b0, cnt_inc} == ({1'b0, length_field_nxt} + FRAME_OVERHEAD));
      if (frame_end) begin
        if (running_sum_nxt == GOOD_SUM) begin
          res_nxt.status = ST_GOOD;
        end else begin
          res_nxt.status = ST_BAD;
          err_count_nxt  = err1 + 16'd1;
        end
        byte_count_nxt   = 16'd0;
        length_field_nxt = 16'd0;
        running_sum_nxt  = 8'd0;
      end
    end
    res_nxt.error_total = err_count_nxt;
  end

  // Hold frame state, limit and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_limit_r  <= LIMIT_RESET;
      byte_count_r   <= 16'd0;
      length_field_r <= 16'd0;
      length_high_r  <= 8'd0;
      running_sum_r  <= 8'd0;
      err_count_r    <= 16'd0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        frame_limit_r <= cfg_wr_data;
      end
      if (acc) begin
        byte_count_r   <= byte_count_nxt;
        length_field_r <= length_field_nxt;
        length_high_r  <= length_high_nxt;
        running_sum_r  <= running_sum_nxt;
        err_count_r    <= err_count_nxt;
        out_valid_r    <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

  // An overflow drop always moves the error count
  a_ovf_counts: assert property (@(posedge clk) disable iff (!rst_n)
    acc && ovf |=> err_count_r != $past(err_count_r))
    else $error("overflow drop not counted");

  // A frame end clears the byte count
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && frame_end |=> byte_count_r == 16'd0)
    else $error("byte count not cleared at frame end");

  // An end verdict belongs to a frame past its header with a length
  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.status == ST_GOOD || res_r.status == ST_BAD) |->
      res_r.payload_length != 16'd0 && res_r.byte_position >= HDR_LAST_POS)
    else $error("frame end verdict on a malformed position");

  // A rejected byte carries no position or length
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.status == ST_REJECT |->
      res_r.byte_position == 16'd0 && res_r.payload_length == 16'd0)
    else $error("rejected byte with frame position");

endmodule

/* design/api_frame_receiver.sv */
// ----------------------------------------------------------------------------
// api_frame_receiver
// Byte-serial API frame deframer with 8-bit checksum check, overflow drop
// and a wrapping error counter.
//
//   port group   direction   handshake            payload
//   in_          input       in_valid / in_stall  in_rx_byte
//   out_         output      out_valid/out_stall  status, drop, byte, pos, len, errors
//   cfg_         input       cfg_wr_en            cfg_wr_data (frame_limit)
//
// One item per cycle sustained while out_stall is low; an accepted byte is
// loaded into the input register and then, through the frame logic, into
// the result register, which raises out_valid.
// The running sum and counters update in one pass, so each byte is final
// before the next arrives. Reset (rst_n low, synchronous) clears all frame
// state and the error count and sets frame_limit to 128. A stall on the
// result side holds the result register and backs up into in_stall only
// once the input register is also full.
// ----------------------------------------------------------------------------
module api_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_overflow_drop,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_byte_position,
  output logic [15:0] out_payload_length,
  output logic [15:0] out_error_total,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import afr_pkg::*;

  afr_item_t   item;
  afr_result_t res;
  logic        take;

  // Input register
  afr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .take       (take),
    .item       (item)
  );

  // Frame logic and result register
  afr_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .take        (take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .res         (res)
  );

  // Break out the result fields
  assign out_status         = res.status;
  assign out_overflow_drop  = res.overflow_drop;
  assign out_data_byte      = res.data_byte;
  assign out_byte_position  = res.byte_position;
  assign out_payload_length = res.payload_length;
  assign out_error_total    = res.error_total;

endmodule
